// File: hw/rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants for the bounded priority admission block.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int CAP_W     = 5;
    localparam int ID_W      = 16;
    localparam int FEE_W     = 32;
    localparam int TS_W      = 32;
    localparam int OCC_W     = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // one held transaction
    typedef struct packed {
        logic [TS_W-1:0]  tstamp;
        logic [FEE_W-1:0] fee;
        logic [ID_W-1:0]  id;
    } entry_t;

    // row-wide commit control
    typedef struct packed {
        logic upd;   // commit the new row contents
        logic repl;  // replace the lowest entry instead of appending
    } row_ctl_t;

endpackage

// File: hw/rtl/bounded_priority_admission.sv
// ----------------------------------------------------------------------------
// bounded_priority_admission
// Keeps up to capacity transactions, admitting a new one over the held
// lowest-fee entry when its fee is strictly higher.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one offered transaction (id, fee, timestamp).
//   m_ channel returns one result per transaction: accepted, evicted, the
//   evicted id and fee (zero when nothing was evicted) and the occupancy.
//   cfg_ channel writes the capacity (0 acts as 1, values above DEPTH act as
//   DEPTH); write it only while no transaction is in flight.
//   Held entries sit in a row of cells sorted by priority, so the entry to
//   evict is always in the first cell. Every cell compares itself against
//   the new transaction at once and the whole row shifts on a single commit.
//   The result is registered: the output register takes it when the
//   transaction leaves the input register, which holds a transaction until
//   the cell row has committed it and takes no new one until then.
//   Reset empties the store and sets capacity to 16. While m_tready is low
//   the result stays in the output register; one more transaction may be
//   taken in and waits in the input register until the result is taken.
// ----------------------------------------------------------------------------
module bounded_priority_admission #(
    parameter int DEPTH = bpa_pkg::DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [79:0]                s_tdata,   // tx_id, tx_fee, tx_time
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [55:0]                m_tdata,   // accepted, evicted, evicted_id,
                                                  // evicted_fee, occupancy, pad
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [bpa_pkg::CAP_W-1:0]  cfg_data   // capacity
);
    import bpa_pkg::*;

    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              in_valid_reg, in_valid_next;
    entry_t            in_entry_reg;
    logic              out_valid_reg, out_valid_next;
    logic [55:0]       out_data_reg;

    logic [CMP_W-1:0]  eff_cap, cap_ext, cnt_ext;
    logic              full, fill, repl_ok, fire;
    logic [SLOT_W-1:0] key_slot;
    row_ctl_t          ctl;
    logic [ID_W-1:0]   ev_id;
    logic [FEE_W-1:0]  ev_fee;

    entry_t            c_entry [DEPTH];
    logic [SLOT_W-1:0] c_slot  [DEPTH];
    logic              c_below [DEPTH];

    // capacity register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_valid) begin
            cap_reg <= cfg_data;
        end
    end

    assign cap_ext = CMP_W'(cap_reg);
    assign cnt_ext = CMP_W'(count_reg);

    always_comb begin
        eff_cap = cap_ext;
        if (cap_ext == '0) begin
            eff_cap = CMP_W'(1);
        end else if (cap_ext > CMP_W'(DEPTH)) begin
            eff_cap = CMP_W'(DEPTH);
        end
    end

    // admission decision
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign full     = !(cnt_ext < eff_cap && cnt_ext < CMP_W'(DEPTH));
    assign fill     = !full;
    assign repl_ok  = full && (count_reg != '0) && (in_entry_reg.fee > c_entry[0].fee);
    assign key_slot = full ? c_slot[0] : count_reg[SLOT_W-1:0];

    assign ctl.upd  = fire && (fill || repl_ok);
    assign ctl.repl = full;

    assign ev_id  = repl_ok ? c_entry[0].id  : '0;
    assign ev_fee = repl_ok ? c_entry[0].fee : '0;

    // cell row, first cell holds the lowest-priority entry
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        entry_t            l_entry, r_entry;
        logic [SLOT_W-1:0] l_slot, r_slot;
        logic              l_below, r_below;

        if (i == 0) begin : g_first
            assign l_entry = '0;
            assign l_slot  = '0;
            assign l_below = 1'b1;
        end else begin : g_mid_l
            assign l_entry = c_entry[i-1];
            assign l_slot  = c_slot[i-1];
            assign l_below = c_below[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign r_entry = '0;
            assign r_slot  = '0;
            assign r_below = 1'b0;
        end else begin : g_mid_r
            assign r_entry = c_entry[i+1];
            assign r_slot  = c_slot[i+1];
            assign r_below = c_below[i+1];
        end

        bpa_cell #(
            .INDEX  (i),
            .SLOT_W (SLOT_W),
            .CNT_W  (CNT_W)
        ) u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .held_count  (count_reg),
            .key_entry   (in_entry_reg),
            .key_slot    (key_slot),
            .left_entry  (l_entry),
            .left_slot   (l_slot),
            .left_below  (l_below),
            .right_entry (r_entry),
            .right_slot  (r_slot),
            .right_below (r_below),
            .own_entry   (c_entry[i]),
            .own_slot    (c_slot[i]),
            .own_below   (c_below[i])
        );
    end

    // input stage
    assign s_tready = !in_valid_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_entry_reg.id     <= s_tdata[15:0];
            in_entry_reg.fee    <= s_tdata[47:16];
            in_entry_reg.tstamp <= s_tdata[79:48];
        end
    end

    // occupancy and output stage
    assign count_next = (fire && fill) ? count_reg + CNT_W'(1) : count_reg;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= {1'b0, OCC_W'(count_next), ev_fee, ev_id,
                             repl_ok, fill || repl_ok};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: hw/rtl/bpa_cell.sv
// ----------------------------------------------------------------------------
// bpa_cell
// One position of the sorted entry row. Keeps its entry and slot number,
// compares them against the offered key and takes its next contents from
// itself, the key or a neighbor.
// ----------------------------------------------------------------------------
module bpa_cell #(
    parameter int INDEX  = 0,
    parameter int SLOT_W = 4,
    parameter int CNT_W  = 5
) (
    input  logic               aclk,
    input  bpa_pkg::row_ctl_t  ctl,
    input  logic [CNT_W-1:0]   held_count,
    input  bpa_pkg::entry_t    key_entry,
    input  logic [SLOT_W-1:0]  key_slot,
    input  bpa_pkg::entry_t    left_entry,
    input  logic [SLOT_W-1:0]  left_slot,
    input  logic               left_below,
    input  bpa_pkg::entry_t    right_entry,
    input  logic [SLOT_W-1:0]  right_slot,
    input  logic               right_below,
    output bpa_pkg::entry_t    own_entry,
    output logic [SLOT_W-1:0]  own_slot,
    output logic               own_below
);
    import bpa_pkg::*;

    entry_t            entry_reg, entry_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              occupied;
    logic              fee_lt, fee_eq, ts_gt, ts_eq, slot_lt;

    assign occupied = CNT_W'(INDEX) < held_count;

    // order: lower fee, then newer timestamp, then lower slot is lower priority
    assign fee_lt  = entry_reg.fee < key_entry.fee;
    assign fee_eq  = entry_reg.fee == key_entry.fee;
    assign ts_gt   = entry_reg.tstamp > key_entry.tstamp;
    assign ts_eq   = entry_reg.tstamp == key_entry.tstamp;
    assign slot_lt = slot_reg < key_slot;

    assign own_below = occupied &&
        (fee_lt || (fee_eq && (ts_gt || (ts_eq && slot_lt))));

    always_comb begin
        entry_next = entry_reg;
        slot_next  = slot_reg;
        if (ctl.repl) begin
            // head leaves, entries left of the insertion point move down
            if (right_below) begin
                entry_next = right_entry;
                slot_next  = right_slot;
            end else if (own_below || INDEX == 0) begin
                entry_next = key_entry;
                slot_next  = key_slot;
            end
        end else begin
            // append: entries at or past the insertion point move up
            if (!own_below) begin
                if (left_below) begin
                    entry_next = key_entry;
                    slot_next  = key_slot;
                end else begin
                    entry_next = left_entry;
                    slot_next  = left_slot;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.upd) begin
            entry_reg <= entry_next;
            slot_reg  <= slot_next;
        end
    end

    assign own_entry = entry_reg;
    assign own_slot  = slot_reg;

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bounded_priority_admission. Offered transactions
// run through a cycle-free model of the held store; every result beat is
// compared field by field against the oldest predicted verdict.
// ----------------------------------------------------------------------------
module tb;

    import bpa_pkg::*;

    localparam int SLOTS      = DEPTH_DEF;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_LEN   = 300;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [79:0]      s_tdata;    // tx_id, tx_fee, tx_time
    logic             m_tvalid;
    logic             m_tready;
    logic [55:0]      m_tdata;    // accepted, evicted, evicted_id, evicted_fee,
                                  // occupancy, pad
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data;

    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    logic        hold_trig;
    int unsigned idle_cycles;

    class admission_scoreboard;
        typedef struct {
            logic             accepted;
            logic             evicted;
            logic [ID_W-1:0]  ev_id;
            logic [FEE_W-1:0] ev_fee;
            logic [OCC_W-1:0] occ;
        } verdict_t;

        logic [ID_W-1:0]  slot_id   [SLOTS];
        logic [FEE_W-1:0] slot_fee  [SLOTS];
        logic [TS_W-1:0]  slot_time [SLOTS];
        int unsigned      held;
        logic [CAP_W-1:0] capacity;
        verdict_t         verdict_q [$];
        int               errors;

        function new();
            capacity = CAP_RESET;
            held     = 0;
            errors   = 0;
        endfunction

        function void write_capacity(logic [CAP_W-1:0] value);
            capacity = value;
        endfunction

        function void note_offer(logic [79:0] d);
            logic [ID_W-1:0]  id;
            logic [FEE_W-1:0] fee;
            logic [TS_W-1:0]  ts;
            int unsigned      lim;
            int unsigned      low;
            verdict_t         v;
            id  = d[15:0];
            fee = d[47:16];
            ts  = d[79:48];
            v.accepted = 1'b0;
            v.evicted  = 1'b0;
            v.ev_id    = '0;
            v.ev_fee   = '0;
            lim = (capacity == 0) ? 1 : ((capacity > SLOTS) ? SLOTS : capacity);
            if (held < lim) begin
                slot_id[held]   = id;
                slot_fee[held]  = fee;
                slot_time[held] = ts;
                held++;
                v.accepted = 1'b1;
            end else if (held > 0) begin
                // lowest fee, newest timestamp on a fee tie, first slot on a full tie
                low = 0;
                for (int i = 1; i < held; i++) begin
                    if (slot_fee[i] < slot_fee[low] ||
                        (slot_fee[i] == slot_fee[low] && slot_time[i] > slot_time[low]))
                        low = i;
                end
                if (fee > slot_fee[low]) begin
                    v.accepted     = 1'b1;
                    v.evicted      = 1'b1;
                    v.ev_id        = slot_id[low];
                    v.ev_fee       = slot_fee[low];
                    slot_id[low]   = id;
                    slot_fee[low]  = fee;
                    slot_time[low] = ts;
                end
            end
            v.occ = held[OCC_W-1:0];
            verdict_q.push_back(v);
        endfunction

        function void check_result(logic [55:0] d);
            verdict_t want;
            if (verdict_q.size() == 0) begin
                $error("result transaction with no offer pending: %h", d);
                errors++;
                return;
            end
            want = verdict_q.pop_front();
            if (d[0] !== want.accepted) begin
                $error("accepted: expected %0d, actual %0d", want.accepted, d[0]);
                errors++;
            end
            if (d[1] !== want.evicted) begin
                $error("evicted: expected %0d, actual %0d", want.evicted, d[1]);
                errors++;
            end
            if (d[17:2] !== want.ev_id) begin
                $error("evicted_id: expected %h, actual %h", want.ev_id, d[17:2]);
                errors++;
            end
            if (d[49:18] !== want.ev_fee) begin
                $error("evicted_fee: expected %h, actual %h", want.ev_fee, d[49:18]);
                errors++;
            end
            if (d[54:50] !== want.occ) begin
                $error("occupancy: expected %0d, actual %0d", want.occ, d[54:50]);
                errors++;
            end
        endfunction
    endclass

    admission_scoreboard sb = new();

    bounded_priority_admission uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // observe handshakes on the edge, before any driven change lands
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (s_tvalid && s_tready)
                sb.note_offer(s_tdata);
            if (cfg_valid && cfg_ready)
                sb.write_capacity(cfg_data);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[bounded_priority_admission] ERROR");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off on request
    initial begin
        logic        hold_seen;
        int unsigned hold_left;
        hold_seen = 1'b0;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_trig != hold_seen) begin
                hold_seen = hold_trig;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    task automatic send_tx(input logic [15:0] id, input logic [31:0] fee,
                           input logic [31:0] ts);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ts, fee, id};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        // let the monitor record the last accepted offer first
        @(posedge aclk);
        while (sb.verdict_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] value);
        drain();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // fees cluster around a per-phase base so that entries keep turning over
    task automatic run_phase(input logic [CAP_W-1:0] cap, input int unsigned src_pct,
                             input int unsigned sink_pct, input logic [31:0] base,
                             input int unsigned count, input logic long_hold);
        logic [31:0] fee;
        logic [31:0] ts;
        set_capacity(cap);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        if (long_hold)
            hold_trig <= ~hold_trig;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 7) == 0)
                fee = $urandom;
            else
                fee = base + $urandom_range(0, 63) + n;
            if ($urandom_range(0, 1) == 0)
                ts = $urandom_range(0, 7);
            else
                ts = $urandom;
            send_tx(16'($urandom), fee, ts);
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        hold_trig      = 1'b0;
        idle_cycles    = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // capacity zero acts as one
        set_capacity(5'd0);
        send_tx(16'h0001, 32'd10, 32'd1);
        send_tx(16'h0002, 32'd10, 32'd2);    // equal fee, rejected
        send_tx(16'h0003, 32'd11, 32'd3);

        set_capacity(5'd4);
        send_tx(16'h0000, 32'd0, 32'd0);
        send_tx(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_tx(16'h1234, 32'd100, 32'd50);
        send_tx(16'h0007, 32'd0, 32'd9);     // equal to the minimum fee
        send_tx(16'h2222, 32'd1, 32'd3);
        send_tx(16'h3333, 32'd100, 32'd60);
        send_tx(16'h0011, 32'd101, 32'd50);
        send_tx(16'h0012, 32'd102, 32'd5);   // fee tie, newest goes
        send_tx(16'h5555, 32'd101, 32'd50);
        send_tx(16'h6666, 32'd500, 32'd2);   // full tie, first slot goes

        // capacity below the held count keeps every entry
        set_capacity(5'd2);
        send_tx(16'h8000, 32'h8000_0000, 32'h8000_0000);
        send_tx(16'h7FFF, 32'd1, 32'h7FFF_FFFF);

        // above the built depth saturates
        set_capacity(5'd31);
        send_tx(16'hA5A5, 32'h5A5A_5A5A, 32'd7);
        send_tx(16'h5A5A, 32'hA5A5_A5A5, 32'd7);

        run_phase(5'd8,  0,  0,  32'h0000_0000, 90, 1'b0);
        run_phase(5'd12, 74, 0,  32'h3333_3333, 90, 1'b0);
        run_phase(5'd1,  0,  74, 32'h6666_6666, 90, 1'b0);
        run_phase(5'd16, 22, 22, 32'h9999_9999, 90, 1'b0);
        run_phase(5'd5,  0,  0,  32'hCCCC_CCCC, 73, 1'b1);

        drain();
        if (sb.errors == 0 && sb.verdict_q.size() == 0) begin
            $display("[bounded_priority_admission] OK");
        end else begin
            $display("[bounded_priority_admission] ERROR");
        end
        $finish;
    end

endmodule
